>>> rtl/cwa_pkg.sv
// shared types and constants for the cascaded window average unit
package cwa_pkg;

  localparam int SAMPLE_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    LVL_SHORT,
    LVL_MID,
    LVL_LONG
  } level_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } lvl_ctrl_t;

  function automatic level_t next_level(level_t lvl);
    level_t res;
    case (lvl)
      LVL_SHORT: res = LVL_MID;
      LVL_MID:   res = LVL_LONG;
      default:   res = LVL_LONG;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/cwa_level.sv
// one window level: circular store, running sum, write position and full flag
module cwa_level #(
  parameter int DEPTH = 60,
  parameter int SUM_W = 22,
  parameter int OUT_W = 22,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cwa_pkg::lvl_ctrl_t                ctrl,
  input  logic signed [cwa_pkg::SAMPLE_W-1:0] value,
  output logic signed [OUT_W-1:0]           sum_o,
  output logic [CNT_W-1:0]                  count_o,
  output logic                              cascade_o
);
  import cwa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] old_r;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic                       full_r, full_nxt;
  logic                       cascade_r, cascade_nxt;
  logic                       last;

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      old_r <= mem[pos_r];
    end
    if (ctrl.wr) begin
      mem[pos_r] <= value;
    end
  end

  always_comb begin
    last        = (pos_r == PW'(DEPTH - 1));
    sum_nxt     = sum_r - (full_r ? SUM_W'(old_r) : '0) + SUM_W'(value);
    count_nxt   = full_r ? CNT_W'(DEPTH) : CNT_W'(pos_r) + CNT_W'(1);
    cascade_nxt = ((pos_r == '0) && !full_r) || last;
    pos_nxt     = last ? '0 : pos_r + PW'(1);
    full_nxt    = full_r | last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      count_r   <= CNT_W'(1);
      pos_r     <= '0;
      full_r    <= 1'b0;
      cascade_r <= 1'b0;
    end else if (ctrl.wr) begin
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      full_r    <= full_nxt;
      cascade_r <= cascade_nxt;
    end
  end

  assign sum_o     = OUT_W'(sum_r);
  assign count_o   = count_r;
  assign cascade_o = cascade_r;

endmodule

>>> rtl/cwa_div.sv
// shared serial signed divider, one quotient bit per cycle, truncating toward zero
module cwa_div #(
  parameter int DW = 22,
  parameter int CW = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [DW-1:0]              dividend,
  input  logic [CW-1:0]                     divisor,
  output logic                              done,
  output logic signed [cwa_pkg::SAMPLE_W-1:0] quotient
);
  import cwa_pkg::*;

  localparam int CNTW = $clog2(DW);

  logic [DW-1:0]   q_r;
  logic [CW-1:0]   rem_r;
  logic [CW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [CW:0]     rem_sh;
  logic [CW:0]     rem_sub;
  logic            qbit;
  logic [DW-1:0]   q_signed;

  always_comb begin
    rem_sh   = {rem_r, q_r[DW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    qbit     = (rem_sh >= {1'b0, dvs_r});
    q_signed = neg_r ? (~q_r + DW'(1)) : q_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[DW-1];
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], qbit};
      rem_r <= qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_signed[SAMPLE_W-1:0];

endmodule

>>> rtl/cascaded_window_average_unit.sv
// top level: sequencer running three window levels through one shared divider
//
// input channel in_*: one signed 16-bit temperature sample per transfer,
// in units of 1/256 degree. output channel out_*: one result per sample
// with the short, mid and long averages and two flags telling whether the
// mid and long windows took a new entry on this sample.
// each sample walks the levels in turn, short first, then mid and long only
// while the previous level cascades. per level the sequencer reads the entry
// being replaced, updates the running sum, starts the divider, waits for the
// serial divider to work through a DIV_W-bit dividend (DIV_W is the widest
// running sum, 16 + clog2(depth) bits, 22 at the default depths) and takes
// the quotient. after the last visited level the result is loaded into the
// output register and the sequencer returns to idle.
// in_tready is high only while the sequencer is idle. the result sits in an
// output register, so a stalled receiver holds it while the next sample is
// accepted; the sequencer only waits if a second result is ready first.
// synchronous reset clears sums, positions, full flags and averages; window
// stores need no clearing since an old entry enters a sum only once written.
module cascaded_window_average_unit #(
  parameter int SHORT_DEPTH = 60,
  parameter int MID_DEPTH   = 60,
  parameter int LONG_DEPTH  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // short_average[15:0], mid_average[31:16], long_average[47:32]
  output logic [1:0]  out_tuser   // mid_updated[0], long_updated[1]
);
  import cwa_pkg::*;

  localparam int SHORT_SUM_W = SAMPLE_W + $clog2(SHORT_DEPTH);
  localparam int MID_SUM_W   = SAMPLE_W + $clog2(MID_DEPTH);
  localparam int LONG_SUM_W  = SAMPLE_W + $clog2(LONG_DEPTH);
  localparam int SM_W   = (SHORT_SUM_W > MID_SUM_W) ? SHORT_SUM_W : MID_SUM_W;
  localparam int DIV_W  = (SM_W > LONG_SUM_W) ? SM_W : LONG_SUM_W;
  localparam int SM_D   = (SHORT_DEPTH > MID_DEPTH) ? SHORT_DEPTH : MID_DEPTH;
  localparam int MAX_D  = (SM_D > LONG_DEPTH) ? SM_D : LONG_DEPTH;
  localparam int CNT_W  = $clog2(MAX_D + 1);

  state_t state_r, state_nxt;
  level_t lvl_r;

  logic signed [SAMPLE_W-1:0] value_r;
  logic signed [SAMPLE_W-1:0] short_avg_r, mid_avg_r, long_avg_r;
  logic [1:0]                 upd_r;

  lvl_ctrl_t short_ctrl, mid_ctrl, long_ctrl;

  logic signed [DIV_W-1:0] short_sum, mid_sum, long_sum, cur_sum;
  logic [CNT_W-1:0]        short_cnt, mid_cnt, long_cnt, cur_cnt;
  logic                    short_casc, mid_casc, long_casc, cur_casc;

  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_free;

  cwa_level #(
    .DEPTH (SHORT_DEPTH),
    .SUM_W (SHORT_SUM_W),
    .OUT_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_short (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (short_ctrl),
    .value     (value_r),
    .sum_o     (short_sum),
    .count_o   (short_cnt),
    .cascade_o (short_casc)
  );

  cwa_level #(
    .DEPTH (MID_DEPTH),
    .SUM_W (MID_SUM_W),
    .OUT_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mid_ctrl),
    .value     (value_r),
    .sum_o     (mid_sum),
    .count_o   (mid_cnt),
    .cascade_o (mid_casc)
  );

  cwa_level #(
    .DEPTH (LONG_DEPTH),
    .SUM_W (LONG_SUM_W),
    .OUT_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_long (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (long_ctrl),
    .value     (value_r),
    .sum_o     (long_sum),
    .count_o   (long_cnt),
    .cascade_o (long_casc)
  );

  cwa_div #(
    .DW (DIV_W),
    .CW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_sum),
    .divisor  (cur_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (lvl_r)
      LVL_SHORT: begin
        cur_sum  = short_sum;
        cur_cnt  = short_cnt;
        cur_casc = short_casc;
      end
      LVL_MID: begin
        cur_sum  = mid_sum;
        cur_cnt  = mid_cnt;
        cur_casc = mid_casc;
      end
      default: begin
        cur_sum  = long_sum;
        cur_cnt  = long_cnt;
        cur_casc = long_casc;
      end
    endcase
  end

  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (cur_casc && (lvl_r != LVL_LONG)) ? ST_READ : ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    lvl_ctrl_t c;
    c          = '0;
    in_tready  = 1'b0;
    div_start  = 1'b0;
    short_ctrl = '0;
    mid_ctrl   = '0;
    long_ctrl  = '0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_READ:   c.rd = 1'b1;
      ST_UPDATE: c.wr = 1'b1;
      ST_START:  div_start = 1'b1;
      default:   c = '0;
    endcase
    case (lvl_r)
      LVL_SHORT: short_ctrl = c;
      LVL_MID:   mid_ctrl   = c;
      default:   long_ctrl  = c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lvl_r        <= LVL_SHORT;
      upd_r        <= '0;
      short_avg_r  <= '0;
      mid_avg_r    <= '0;
      long_avg_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            lvl_r <= LVL_SHORT;
            upd_r <= '0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            case (lvl_r)
              LVL_SHORT: begin
                short_avg_r <= div_q;
                upd_r[0]    <= cur_casc;
              end
              LVL_MID: begin
                mid_avg_r <= div_q;
                upd_r[1]  <= cur_casc;
              end
              default: long_avg_r <= div_q;
            endcase
            if (cur_casc && (lvl_r != LVL_LONG)) begin
              lvl_r <= next_level(lvl_r);
            end
          end
        end
        default: lvl_r <= lvl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_tvalid) begin
      value_r <= in_tdata;
    end else if ((state_r == ST_DIV) && div_done) begin
      value_r <= div_q;
    end
    if ((state_r == ST_OUT) && out_free) begin
      out_tdata_r <= {long_avg_r, mid_avg_r, short_avg_r};
      out_tuser_r <= upd_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_READ))
    else $error("accepted sample did not start the short level");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide wait");

  a_long_needs_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("long update flagged without mid update");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside the output step");
`endif

endmodule

>>> sim/window_average_checker.sv
// checker for the cascaded window average unit: predicts each result and compares it
module window_average_checker #(
  parameter int SHORT_DEPTH = 60,
  parameter int MID_DEPTH   = 60,
  parameter int LONG_DEPTH  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // short_average[15:0], mid_average[31:16], long_average[47:32]
  input  logic [1:0]  out_tuser,  // mid_updated[0], long_updated[1]
  input  logic        end_of_test,
  output int          outstanding,
  output int          fail_count
);
  import cwa_pkg::*;

  localparam int MAX_DEPTH = (SHORT_DEPTH > MID_DEPTH) ?
    ((SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH) :
    ((MID_DEPTH > LONG_DEPTH) ? MID_DEPTH : LONG_DEPTH);

  typedef struct packed {
    logic [SAMPLE_W-1:0] short_avg;
    logic [SAMPLE_W-1:0] mid_avg;
    logic [SAMPLE_W-1:0] long_avg;
    logic                mid_upd;
    logic                long_upd;
  } window_result_t;

  logic signed [SAMPLE_W-1:0] win [3][MAX_DEPTH];
  logic signed [SAMPLE_W-1:0] level_avg [3];
  longint                     run_sum [3];
  int                         wr_pos [3];
  logic [2:0]                 filled;

  window_result_t expected_averages [$];
  window_result_t exp_r;
  window_result_t got_r;
  int             n_results;
  logic           to_mid;
  logic           to_long;
  logic           leftover_checked;

  function automatic int depth_of(input level_t lvl);
    int d;
    case (lvl)
      LVL_SHORT: d = SHORT_DEPTH;
      LVL_MID:   d = MID_DEPTH;
      default:   d = LONG_DEPTH;
    endcase
    return d;
  endfunction

  // writes one entry into a window; returns 1 when the next level takes an entry
  function automatic logic push_window(input level_t lvl, input logic signed [SAMPLE_W-1:0] value);
    int     d;
    int     p;
    logic   full;
    logic   cascade;
    longint count;
    d = depth_of(lvl);
    p = wr_pos[lvl];
    full = filled[lvl];
    if (p >= d) p = 0;
    // overwritten entry leaves the running sum
    if (full) run_sum[lvl] -= longint'(win[lvl][p]);
    win[lvl][p] = value;
    run_sum[lvl] += longint'(value);
    count = full ? longint'(d) : longint'(p + 1);
    level_avg[lvl] = SAMPLE_W'(run_sum[lvl] / count);
    cascade = (p == 0) && !full;
    p++;
    if (p >= d) begin
      p = 0;
      filled[lvl] = 1'b1;
      cascade = 1'b1;
    end
    wr_pos[lvl] = p;
    return cascade;
  endfunction

  task automatic report(input string msg);
    if (fail_count < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                             input logic [SAMPLE_W-1:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0d expected %0d", n_results, name,
                       $signed(got), $signed(want)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < 3; l++) begin
        run_sum[l] = 0;
        wr_pos[l] = 0;
        level_avg[l] = '0;
      end
      filled = '0;
      expected_averages.delete();
      n_results = 0;
      leftover_checked = 1'b0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_r = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser[0], out_tuser[1]};
        if (expected_averages.size() == 0) begin
          report($sformatf("result %0d arrived with no sample outstanding", n_results));
        end else begin
          exp_r = expected_averages.pop_front();
          check_field("short_average", got_r.short_avg, exp_r.short_avg);
          check_field("mid_average", got_r.mid_avg, exp_r.mid_avg);
          check_field("long_average", got_r.long_avg, exp_r.long_avg);
          check_field("mid_updated", SAMPLE_W'(got_r.mid_upd), SAMPLE_W'(exp_r.mid_upd));
          check_field("long_updated", SAMPLE_W'(got_r.long_upd), SAMPLE_W'(exp_r.long_upd));
        end
        n_results++;
      end
      if (in_tvalid && in_tready) begin
        to_long = 1'b0;
        to_mid = push_window(LVL_SHORT, in_tdata);
        if (to_mid) begin
          to_long = push_window(LVL_MID, level_avg[LVL_SHORT]);
          if (to_long) void'(push_window(LVL_LONG, level_avg[LVL_MID]));
        end
        exp_r.short_avg = level_avg[LVL_SHORT];
        exp_r.mid_avg = level_avg[LVL_MID];
        exp_r.long_avg = level_avg[LVL_LONG];
        exp_r.mid_upd = to_mid;
        exp_r.long_upd = to_long;
        expected_averages.push_back(exp_r);
      end
      if (end_of_test && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_averages.size() != 0)
          report($sformatf("%0d results never arrived", expected_averages.size()));
      end
      outstanding <= expected_averages.size();
    end
  end

endmodule

>>> sim/cascaded_window_average_unit_tb.sv
// testbench top for the cascaded window average unit: clock, reset, stimulus and verdict
module cascaded_window_average_unit_tb;

  localparam int SHORT_DEPTH  = 60;
  localparam int MID_DEPTH    = 60;
  localparam int LONG_DEPTH   = 24;
  localparam int N_RANDOM     = 1650;
  localparam int N_FLOOD      = 16;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sample[15:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // short_average[15:0], mid_average[31:16], long_average[47:32]
  logic [1:0]  out_tuser;  // mid_updated[0], long_updated[1]

  logic        hold_off_req;
  logic        hold_active;
  logic        end_of_test;
  int          outstanding;
  int          fail_count;
  int          cycle_count;

  cascaded_window_average_unit #(
    .SHORT_DEPTH (SHORT_DEPTH),
    .MID_DEPTH   (MID_DEPTH),
    .LONG_DEPTH  (LONG_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  window_average_checker #(
    .SHORT_DEPTH (SHORT_DEPTH),
    .MID_DEPTH   (MID_DEPTH),
    .LONG_DEPTH  (LONG_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .end_of_test (end_of_test),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // sample mix: extremes, values near room temperature, full-range noise
  function automatic logic [15:0] pick_sample(input int mode);
    logic [15:0] s;
    case (mode)
      0: s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h7FFF;
      1: s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h8000;
      2: s = 16'h1900 + 16'($urandom_range(0, 2047)) - 16'd1024;
      default: begin
        case ($urandom_range(0, 9))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'h0000;
          3:       s = 16'hFFFF;
          default: s = 16'($urandom);
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(input logic [15:0] s);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_bursts(input int n_items);
    int sent;
    int burst;
    int mode;
    int gap;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
      mode = $urandom_range(0, 5);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_sample(pick_sample(mode));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, ready stretches, one long hold-off on request
  initial begin
    int ready_run;
    int stall_run;
    out_tready  <= 1'b0;
    hold_active <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_active) begin
        out_tready  <= 1'b0;
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          ready_run = $urandom_range(20, 120);
          stall_run = 0;
        end else begin
          ready_run = $urandom_range(1, 6);
          stall_run = $urandom_range(1, 15);
        end
        out_tready <= 1'b1;
        repeat (ready_run) @(posedge clk);
        if (stall_run > 0) begin
          out_tready <= 1'b0;
          repeat (stall_run) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [15:0] directed [20];
    directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE,
                 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1900, 16'hE700, 16'h7FFF,
                 16'h7FFF, 16'h8000, 16'h8000, 16'h0080, 16'hFF80, 16'h0000};
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    hold_off_req <= 1'b0;
    end_of_test  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, alternating bit patterns, sign changes, partial window
    foreach (directed[i]) send_sample(directed[i]);
    drain_results();

    // long receiver hold-off while the sender keeps offering back to back
    hold_off_req <= 1'b1;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < N_FLOOD; i++) send_sample(pick_sample(3));

    run_bursts(N_RANDOM / 2 - N_FLOOD);
    drain_results();
    run_bursts(N_RANDOM - N_RANDOM / 2);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cwa_pkg.sv
rtl/cwa_level.sv
rtl/cwa_div.sv
rtl/cascaded_window_average_unit.sv
sim/window_average_checker.sv
sim/cascaded_window_average_unit_tb.sv
